@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the 5-smooth number generator.
// Depends on nothing; expects aclk and aresetn in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HNG_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define HNG_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/hng_pkg.sv @@
// Package for the 5-smooth number generator: widths, sequencer states,
// factor codes and the shared constant-multiply unit. Depends on nothing.
package hng_pkg;

    localparam int POS_W         = 11;
    localparam int VAL_W         = 31;
    localparam int CAND_W        = 34;
    localparam int MAX_INDEX_DEF = 1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_MERGE,
        ST_RDATA,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        FAC_TWO,
        FAC_THREE,
        FAC_FIVE
    } factor_t;

    // One shifter and one adder: x*2, x*3 = 2x + x, x*5 = 4x + x.
    function automatic logic [CAND_W-1:0] scale(input logic [VAL_W-1:0] x,
                                                input factor_t f);
        logic [CAND_W-1:0] xe;
        logic [CAND_W-1:0] shifted;
        logic [CAND_W-1:0] addend;
        xe = CAND_W'(x);
        shifted = '0;
        addend = '0;
        unique case (f)
            FAC_TWO: begin
                shifted = xe << 1;
                addend  = '0;
            end
            FAC_THREE: begin
                shifted = xe << 1;
                addend  = xe;
            end
            FAC_FIVE: begin
                shifted = xe << 2;
                addend  = xe;
            end
            default: begin
                shifted = '0;
                addend  = '0;
            end
        endcase
        return shifted + addend;
    endfunction

endpackage

@@ rtl/hamming_number_generator.sv @@
// Top level of the 5-smooth (Hamming) number generator: sequencer, sequence
// store and output register. Depends on hng_pkg and assert_macros.svh.
//
//  channel | ports                      | direction | handshake
//  --------+----------------------------+-----------+-------------------
//  request | s_position                 | in        | s_valid / s_ready
//  result  | m_value, m_range_error     | out       | m_valid / m_ready
//
// Sequencing: a request whose entry is already stored passes CHECK, RDATA and
// RESP. Each missing entry adds a CHECK and MERGE step plus a CHECK and LOAD
// step per pointer refreshed (one to three); the single read port of the
// sequence store makes the pointers refresh one at a time. Position zero and
// positions above MAX_INDEX go from IDLE straight to RESP.
// Reset: synchronous, active low; clears the fill count and pointers. The
// store is not cleared, as no entry is read before it is written.
// Stalls: s_ready is high only while idle; a result waiting on m_ready holds
// in the output register while the next request is taken and worked on.
`include "assert_macros.svh"

module hamming_number_generator
    import hng_pkg::*;
#(
    parameter int MAX_INDEX = MAX_INDEX_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [POS_W-1:0] s_position,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_value,
    output logic             m_range_error
);

    // Store index and fill count widths follow the store depth.
    localparam int IDX_W = (MAX_INDEX > 1) ? $clog2(MAX_INDEX) : 1;
    localparam int CNT_W = $clog2(MAX_INDEX + 1);

    // Sequence store: one write and one registered read per cycle.
    logic [VAL_W-1:0] store_mem [MAX_INDEX];

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  ptr_two_reg, ptr_two_next;
    logic [IDX_W-1:0]  ptr_three_reg, ptr_three_next;
    logic [IDX_W-1:0]  ptr_five_reg, ptr_five_next;
    logic [CAND_W-1:0] cand_two_reg, cand_two_next;
    logic [CAND_W-1:0] cand_three_reg, cand_three_next;
    logic [CAND_W-1:0] cand_five_reg, cand_five_next;
    // bit 0: factor two, bit 1: factor three, bit 2: factor five
    logic [2:0]        stale_reg, stale_next;
    factor_t           sel_reg, sel_next;
    logic [VAL_W-1:0]  rd_data_reg;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic              res_err_reg, res_err_next;
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;
    logic              m_range_error_reg, m_range_error_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [IDX_W-1:0]  rd_addr;

    logic              in_accept;
    logic              pos_zero;
    logic              pos_over;
    logic              have_entry;
    logic              any_stale;
    logic              out_free;
    factor_t           fetch_sel;
    logic [IDX_W-1:0]  fetch_ptr;
    logic [CAND_W-1:0] least_23;
    logic [CAND_W-1:0] least;
    logic [CAND_W-1:0] scaled;

    assign in_accept  = s_valid && s_ready;
    assign pos_zero   = (s_position == '0);
    assign pos_over   = (s_position > POS_W'(MAX_INDEX));
    assign have_entry = (POS_W'(fill_reg) >= pos_reg);
    assign any_stale  = |stale_reg;
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_range_error = m_range_error_reg;

    // Refresh the stale pointers in fixed order: two, three, five.
    always_comb begin
        if (stale_reg[0]) begin
            fetch_sel = FAC_TWO;
            fetch_ptr = ptr_two_reg;
        end else if (stale_reg[1]) begin
            fetch_sel = FAC_THREE;
            fetch_ptr = ptr_three_reg;
        end else begin
            fetch_sel = FAC_FIVE;
            fetch_ptr = ptr_five_reg;
        end
    end

    // Shared compare unit: least of the three candidates.
    assign least_23 = (cand_two_reg <= cand_three_reg) ? cand_two_reg : cand_three_reg;
    assign least    = (cand_five_reg < least_23) ? cand_five_reg : least_23;

    // Shared multiply unit: scale the fetched entry by the selected factor.
    assign scaled = scale(rd_data_reg, sel_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (pos_zero || pos_over) ? ST_RESP : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (have_entry) begin
                    state_next = ST_RDATA;
                end else if (fill_reg == '0) begin
                    state_next = ST_CHECK;
                end else if (any_stale) begin
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_MERGE;
                end
            end
            ST_LOAD:  state_next = ST_CHECK;
            ST_MERGE: state_next = ST_CHECK;
            ST_RDATA: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and output controls.
    always_comb begin
        pos_next           = pos_reg;
        fill_next          = fill_reg;
        ptr_two_next       = ptr_two_reg;
        ptr_three_next     = ptr_three_reg;
        ptr_five_next      = ptr_five_reg;
        cand_two_next      = cand_two_reg;
        cand_three_next    = cand_three_reg;
        cand_five_next     = cand_five_reg;
        stale_next         = stale_reg;
        sel_next           = sel_reg;
        res_value_next     = res_value_reg;
        res_err_next       = res_err_reg;
        wr_en              = 1'b0;
        wr_addr            = IDX_W'(fill_reg);
        wr_data            = least[VAL_W-1:0];
        rd_addr            = fetch_ptr;
        // Drop the shown result once taken.
        m_valid_next       = m_valid_reg && !m_ready;
        m_value_next       = m_value_reg;
        m_range_error_next = m_range_error_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    pos_next       = s_position;
                    res_value_next = '0;
                    res_err_next   = pos_over;
                end
            end
            ST_CHECK: begin
                if (have_entry) begin
                    // Read the requested entry.
                    rd_addr = IDX_W'(pos_reg - POS_W'(1));
                end else if (fill_reg == '0) begin
                    // Seed the sequence with 1; all candidates need a fetch.
                    wr_en          = 1'b1;
                    wr_addr        = '0;
                    wr_data        = VAL_W'(1);
                    fill_next      = CNT_W'(1);
                    ptr_two_next   = '0;
                    ptr_three_next = '0;
                    ptr_five_next  = '0;
                    stale_next     = 3'b111;
                end else if (any_stale) begin
                    rd_addr  = fetch_ptr;
                    sel_next = fetch_sel;
                end
            end
            ST_LOAD: begin
                case (sel_reg)
                    FAC_TWO: begin
                        cand_two_next = scaled;
                        stale_next[0] = 1'b0;
                    end
                    FAC_THREE: begin
                        cand_three_next = scaled;
                        stale_next[1]   = 1'b0;
                    end
                    default: begin
                        cand_five_next = scaled;
                        stale_next[2]  = 1'b0;
                    end
                endcase
            end
            ST_MERGE: begin
                // Write the least candidate, advance every pointer that met it.
                wr_en     = 1'b1;
                fill_next = fill_reg + CNT_W'(1);
                if (cand_two_reg <= least) begin
                    ptr_two_next  = ptr_two_reg + IDX_W'(1);
                    stale_next[0] = 1'b1;
                end
                if (cand_three_reg <= least) begin
                    ptr_three_next = ptr_three_reg + IDX_W'(1);
                    stale_next[1]  = 1'b1;
                end
                if (cand_five_reg <= least) begin
                    ptr_five_next = ptr_five_reg + IDX_W'(1);
                    stale_next[2] = 1'b1;
                end
            end
            ST_RDATA: begin
                res_value_next = rd_data_reg;
                res_err_next   = 1'b0;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_value_next       = res_value_reg;
                    m_range_error_next = res_err_reg;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequence store: write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            ptr_two_reg   <= '0;
            ptr_three_reg <= '0;
            ptr_five_reg  <= '0;
            stale_reg     <= 3'b111;
            sel_reg       <= FAC_TWO;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ptr_two_reg   <= ptr_two_next;
            ptr_three_reg <= ptr_three_next;
            ptr_five_reg  <= ptr_five_next;
            stale_reg     <= stale_next;
            sel_reg       <= sel_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        pos_reg           <= pos_next;
        cand_two_reg      <= cand_two_next;
        cand_three_reg    <= cand_three_next;
        cand_five_reg     <= cand_five_next;
        res_value_reg     <= res_value_next;
        res_err_reg       <= res_err_next;
        m_value_reg       <= m_value_next;
        m_range_error_reg <= m_range_error_next;
    end

    `HNG_CHECK(a_fill_bound, fill_reg <= CNT_W'(MAX_INDEX), "fill count beyond store depth")
    `HNG_IMPLIES(a_ptr_order, fill_reg != '0,
        (ptr_five_reg <= ptr_three_reg) && (ptr_three_reg <= ptr_two_reg) &&
        (CNT_W'(ptr_two_reg) < fill_reg), "pointer order or bound broken")
    `HNG_IMPLIES(a_err_zero, m_valid && m_range_error, m_value == '0,
        "range error with nonzero value")
    `HNG_CHECK(a_one_in_flight, (s_valid && s_ready) |=> !s_ready,
        "request taken while busy")

endmodule

@@ dv/tb_hamming_number_generator.sv @@
// Self-checking testbench for hamming_number_generator: random and directed
// position requests, a 5-smooth sequence predictor in a scoreboard class.
// Depends on hng_pkg and the RTL of the block; reads no files.
module tb_hamming_number_generator
    import hng_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HNG_LIMIT     = MAX_INDEX_DEF;
    localparam int RANDOM_ITEMS  = 580;
    localparam int SETTLE_CYCLES = 12;
    // A cold walk to the last entry refreshes up to three pointers per entry;
    // every item may also see a long sender gap and a long result stall. The
    // limit allows several times the sum.
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             range_error;
    } smooth_result_t;

    // Scoreboard: keeps its own copy of the sequence store and the three
    // merge pointers, and a queue of results still owed by the block.
    class smooth_sequence_checker;
        logic [VAL_W-1:0] entries [HNG_LIMIT];
        int unsigned      idx_two;
        int unsigned      idx_three;
        int unsigned      idx_five;
        int unsigned      filled;
        smooth_result_t   awaited_results [$];
        int               mismatches;
        int               checked;
        int               zero_requests;
        int               over_requests;
        int               stored_hits;

        task report_mismatch(input string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // Append one entry with the three-pointer merge.
        function void extend_sequence();
            longint unsigned by_two;
            longint unsigned by_three;
            longint unsigned by_five;
            longint unsigned least;
            if (filled >= HNG_LIMIT) return;
            if (filled == 0) begin
                entries[0] = 1;
                idx_two    = 0;
                idx_three  = 0;
                idx_five   = 0;
                filled     = 1;
                return;
            end
            by_two   = 64'(entries[idx_two]) * 2;
            by_three = 64'(entries[idx_three]) * 3;
            by_five  = 64'(entries[idx_five]) * 5;
            least    = (by_two < by_three) ? by_two : by_three;
            if (by_five < least) least = by_five;
            entries[filled] = least[VAL_W-1:0];
            if (by_two <= least) idx_two++;
            if (by_three <= least) idx_three++;
            if (by_five <= least) idx_five++;
            filled++;
        endfunction

        function void note_request(input logic [POS_W-1:0] pos);
            smooth_result_t want;
            want.value       = '0;
            want.range_error = 1'b0;
            if (pos == 0) begin
                zero_requests++;
            end else if (int'(pos) > HNG_LIMIT) begin
                want.range_error = 1'b1;
                over_requests++;
            end else begin
                if (int'(pos) <= filled) stored_hits++;
                while (filled < int'(pos)) extend_sequence();
                want.value = entries[pos - 1];
            end
            awaited_results.push_back(want);
        endfunction

        task check_result(input logic [VAL_W-1:0] value, input logic range_error);
            smooth_result_t want;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing awaited: value %0d range %0b",
                                          value, range_error));
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (value !== want.value)
                report_mismatch($sformatf("value %0d, predicted %0d (result %0d)",
                                          value, want.value, checked));
            if (range_error !== want.range_error)
                report_mismatch($sformatf("range_error %0b, predicted %0b (result %0d)",
                                          range_error, want.range_error, checked));
        endtask
    endclass

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [POS_W-1:0] s_position    = '0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [VAL_W-1:0] m_value;
    logic             m_range_error;

    int unsigned      cycle_count   = 0;
    int               requests_sent = 0;
    bit               sender_steady = 1'b0;
    bit               sink_steady   = 1'b0;
    int               stall_left    = 0;

    smooth_sequence_checker sb = new;

    hamming_number_generator #(
        .MAX_INDEX(HNG_LIMIT)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_range_error(m_range_error)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycle_count, sb.awaited_results.size());
        $display("hamming_number_generator regression: fail");
        $finish;
    end

    // Gap length: mostly short, now and then long, none at all in steady runs.
    function automatic int pick_gap(input bit steady);
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: sample the handshake as it stood before this edge, then
    // pick m_ready for the next cycle. Only one assignment to m_ready per edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_value, m_range_error);
        if ($urandom_range(0, 63) == 0)
            sink_steady = !sink_steady;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            stall_left = pick_gap(sink_steady);
            m_ready <= (stall_left == 0);
        end
    end

    // Offer one request and hold it until the block takes it. Lower valid only
    // when a gap follows, so back-to-back items keep valid high.
    task automatic send_position(input logic [POS_W-1:0] pos);
        int gap;
        gap = pick_gap(sender_steady);
        if (gap > 0) begin
            s_valid    <= 1'b0;
            s_position <= POS_W'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(pos);
        requests_sent++;
    endtask

    // Pick a random request. Most items push the generated frontier a few
    // entries further or revisit stored entries; the rest are position zero,
    // out of range, or anything the field allows.
    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        int reach;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 16) return POS_W'($urandom_range(HNG_LIMIT + 1, (1 << POS_W) - 1));
        if (roll < 19) return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        if (roll < 45 && sb.filled > 0) return POS_W'($urandom_range(1, sb.filled));
        reach = sb.filled + $urandom_range(1, 6);
        if (reach > HNG_LIMIT) reach = HNG_LIMIT;
        return POS_W'(reach);
    endfunction

    initial begin
        logic [POS_W-1:0] directed [$];

        // Hold reset, then release it at an edge.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: position zero, the first entries, repeats of stored
        // entries, the top of the field and the first position out of range.
        directed = '{11'd0, 11'd1, 11'd1, 11'd2, 11'd3, 11'd6, 11'd4, 11'd7,
                     11'd12, 11'd13, 11'd2047, 11'd1025, 11'd1536, 11'd0, 11'd10,
                     11'd9, 11'd3, 11'd30, 11'd31, 11'd1365};
        foreach (directed[i])
            send_position(directed[i]);

        // Random part: walk the frontier up, with steady stretches mixed in.
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0)
                sender_steady = !sender_steady;
            send_position(pick_position());
        end

        // Close with the last valid position and its neighbors.
        send_position(11'(HNG_LIMIT));
        send_position(11'(HNG_LIMIT - 1));
        send_position(11'(HNG_LIMIT + 1));
        send_position(11'd1);
        s_valid <= 1'b0;

        // Drain, then allow time for any stray extra result to show up.
        while (sb.awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d position zero, %0d out of range, %0d stored hits)",
                 requests_sent, sb.zero_requests, sb.over_requests, sb.stored_hits);
        $display("checked %0d results, sequence generated to entry %0d, %0d cycles",
                 sb.checked, sb.filled, cycle_count);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("hamming_number_generator regression: pass");
        end else begin
            $display("hamming_number_generator regression: fail");
        end
        $finish;
    end

endmodule
